// ----- hw/rtl/tdp_pkg.sv -----
// Shared constants for the trial division prime test.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tdp_pkg;

  localparam int unsigned CAND_WIDTH    = 32;
  localparam int unsigned DEF_NUM_WIDTH = 32;

endpackage : tdp_pkg

`default_nettype wire

// ----- hw/rtl/tdp_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
// Depends on tdp_pkg for its default width.
`timescale 1ns / 1ps
`default_nettype none

module tdp_div #(
  parameter int unsigned WIDTH = tdp_pkg::DEF_NUM_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  output logic                  done,
  output logic      [WIDTH-1:0] quotient,
  output logic      [WIDTH-1:0] remainder
);
  import tdp_pkg::*;

  localparam int unsigned CNT_W = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  assign trial = {rem_r, quo_r[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (go) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = CNT_W'(WIDTH);
    end else if (cnt_r != '0) begin
      if (!diff[WIDTH]) begin
        rem_nxt = diff[WIDTH-1:0];
        quo_nxt = {quo_r[WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = trial[WIDTH-1:0];
        quo_nxt = {quo_r[WIDTH-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (go) begin
      dvs_r <= divisor;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule : tdp_div

`default_nettype wire

// ----- hw/rtl/trial_division_prime_test.sv -----
// Top level of the trial division prime test: sequencer and result register.
// Depends on tdp_pkg and on the shared divider tdp_div.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// A transaction is accepted at a rising edge with start high and busy low;
// in_candidate carries the number, of which the low NUM_WIDTH bits are tested.
// Exactly one result follows: out_valid is high for one cycle and
// out_is_prime then tells whether the number is prime.
// Numbers below four and even numbers are answered without division, in the
// cycle after they are accepted. Otherwise the odd divisors 3, 5, 7 and so on
// are tried one after another on a single shared restoring divider, which
// yields one quotient bit per cycle. The search ends when the divisor
// exceeds the quotient or a remainder is zero, so a prime near 2^NUM_WIDTH
// needs about 2^(NUM_WIDTH/2 - 1) divisors.
// busy stays high for the whole search.
// The result cannot be held off by the receiver. A new transaction may be
// accepted in the cycle in which the previous result is shown.
// A synchronous reset on rst_n abandons any search and drops busy.
module trial_division_prime_test #(
  parameter int unsigned NUM_WIDTH = tdp_pkg::DEF_NUM_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [tdp_pkg::CAND_WIDTH-1:0] in_candidate,
  output logic                               out_valid,
  output logic                               out_is_prime
);
  import tdp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LAUNCH = 3'b010,
    S_WAIT   = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [NUM_WIDTH-1:0] num_r, num_nxt;
  logic [NUM_WIDTH-1:0] dvs_r, dvs_nxt;
  logic                 valid_r, valid_nxt;
  logic                 prime_r, prime_nxt;
  logic [NUM_WIDTH-1:0] num_in;
  logic                 accept;
  logic                 div_go;
  logic                 div_done;
  logic [NUM_WIDTH-1:0] div_quo;
  logic [NUM_WIDTH-1:0] div_rem;

  assign num_in = NUM_WIDTH'(in_candidate);
  assign accept = start && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    dvs_nxt   = dvs_r;
    valid_nxt = 1'b0;
    prime_nxt = prime_r;
    div_go    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          num_nxt = num_in;
          dvs_nxt = NUM_WIDTH'(3);
          if (num_in < NUM_WIDTH'(2)) begin
            valid_nxt = 1'b1;
            prime_nxt = 1'b0;
          end else if (num_in < NUM_WIDTH'(4)) begin
            valid_nxt = 1'b1;
            prime_nxt = 1'b1;
          end else if (!num_in[0]) begin
            valid_nxt = 1'b1;
            prime_nxt = 1'b0;
          end else begin
            state_nxt = S_LAUNCH;
          end
        end
      end
      S_LAUNCH: begin
        div_go    = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          if (dvs_r > div_quo) begin
            valid_nxt = 1'b1;
            prime_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else if (div_rem == '0) begin
            valid_nxt = 1'b1;
            prime_nxt = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            dvs_nxt   = dvs_r + NUM_WIDTH'(2);
            state_nxt = S_LAUNCH;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    dvs_r   <= dvs_nxt;
    prime_r <= prime_nxt;
  end

  tdp_div #(
    .WIDTH (NUM_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go),
    .dividend  (num_r),
    .divisor   (dvs_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = valid_r;
  assign out_is_prime = prime_r;

endmodule : trial_division_prime_test

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for trial_division_prime_test: directed and random candidates,
// with a built-in primality predictor that checks every verdict as it arrives.
// Depends on tdp_pkg and on the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import tdp_pkg::*;

  localparam int unsigned     TESTED_WIDTH = DEF_NUM_WIDTH;
  localparam longint unsigned TESTED_MASK  = ((64'd1 << (TESTED_WIDTH - 1)) << 1) - 64'd1;
  localparam int unsigned     RANDOM_ITEMS = 100;
  localparam longint unsigned CYCLE_LIMIT  = 40_000_000;

  typedef struct {
    logic [CAND_WIDTH-1:0] cand;
    bit                    is_prime;
  } verdict_t;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  start        = 1'b0;
  logic [CAND_WIDTH-1:0] in_candidate = '0;
  logic                  busy;
  logic                  out_valid;
  logic                  out_is_prime;

  logic [CAND_WIDTH-1:0] pending_candidates[$];
  verdict_t              expected_verdicts[$];
  verdict_t              oldest;
  int unsigned           burst_left = 0;
  int unsigned           gap_left   = 0;
  int unsigned           errors     = 0;
  int unsigned           n_checked  = 0;
  int unsigned           n_primes   = 0;
  longint unsigned       cycle_cnt  = 0;

  trial_division_prime_test dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_candidate (in_candidate),
    .out_valid    (out_valid),
    .out_is_prime (out_is_prime)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit prime_verdict(logic [CAND_WIDTH-1:0] cand);
    longint unsigned n;
    longint unsigned d;
    n = 64'(cand);
    n = n & TESTED_MASK;
    if (n < 2) return 1'b0;
    if (n < 4) return 1'b1;
    if ((n & 64'd1) == 0) return 1'b0;
    for (d = 3; d <= n / d; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_verdicts.push_back('{cand: in_candidate, is_prime: prime_verdict(in_candidate)});
        void'(pending_candidates.pop_front());
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start        <= 1'b0;
          in_candidate <= $urandom;
        end else if (pending_candidates.size() == 0) begin
          start <= 1'b0;
        end else begin
          start        <= 1'b1;
          in_candidate <= pending_candidates[0];
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 6);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual is_prime %0b",
                 $time, out_is_prime);
      end else begin
        oldest = expected_verdicts.pop_front();
        n_checked++;
        if (out_is_prime !== oldest.is_prime) begin
          errors++;
          $display("%0t: candidate %0d is_prime mismatch, expected %0b actual %0b",
                   $time, oldest.cand, oldest.is_prime, out_is_prime);
        end else if (oldest.is_prime) begin
          n_primes++;
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycle_cnt, expected_verdicts.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned small_factors[6];
    int unsigned sel;
    int unsigned w;
    int unsigned a;
    int unsigned b;
    int unsigned f;
    logic [CAND_WIDTH-1:0] n;

    small_factors = '{2, 3, 5, 7, 11, 13};
    pending_candidates = '{0, 1, 2, 3, 4, 5, 7, 9, 11, 13, 15, 25, 49, 121, 169, 10403,
                           65537, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                           32'hFFFF_FFFB, 32'h7FFF_FFFF};
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        w = $urandom_range(2, 20);
        n = $urandom & ((32'd1 << w) - 1);
      end else if (sel < 70) begin
        a = $urandom_range(3, 1023) | 1;
        b = $urandom_range(3, 1023) | 1;
        n = a * b;
      end else if (sel < 90) begin
        f = small_factors[$urandom_range(0, 5)];
        n = f * $urandom_range(1, 32'hFFFF_FFFF / f);
      end else begin
        w = $urandom_range(21, 24);
        n = ($urandom & ((32'd1 << w) - 1)) | 32'd1;
      end
      pending_candidates.push_back(n);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (pending_candidates.size() != 0 || start || expected_verdicts.size() != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Checked %0d verdicts (%0d primes) over %0d cycles.",
             n_checked, n_primes, cycle_cnt);
    $display("Stimulus covered small numbers, squares, semiprimes and full-width values.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d failures.", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/tdp_pkg.sv
hw/rtl/tdp_div.sv
hw/rtl/trial_division_prime_test.sv
sim/tb_top.sv
